// ===== rtl/assert_macros.svh =====
// Assertion macros for the decoder RTL.
// Depends on nothing; files that check their own logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset
`define PRID_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset
`define PRID_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PRID_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define PRID_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/prid_pkg.sv =====
// Shared types, codes and helper functions of the palette RLE decoder.
// Depends on nothing; used by every module of the decoder.
package prid_pkg;

  // Request modes on the input channel
  localparam logic [1:0] MODE_PAL   = 2'd0;
  localparam logic [1:0] MODE_BYTE  = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_RED   = 2'd0;
  localparam logic [1:0] REG_GREEN = 2'd1;
  localparam logic [1:0] REG_BLUE  = 2'd2;

  localparam logic [3:0]  WIDTH_RESET  = 4'd8;
  localparam logic [3:0]  WIDTH_MAX    = 4'd8;
  localparam logic [16:0] FILL_MAX     = 17'h1FFFF;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;
  localparam int          QUEUE_DEPTH  = 4;

  // Request class decided by the front end
  typedef enum logic [2:0] {
    CL_PAL,
    CL_START,
    CL_ZERO,
    CL_RUN,
    CL_COUNT
  } class_t;

  // Queue entry: palette {slot, colour}, byte {0, byte}, start {0, width}
  typedef struct packed {
    class_t      cls;
    logic [31:0] data;
  } item_t;

  typedef struct packed {
    logic [3:0] red;
    logic [3:0] green;
    logic [3:0] blue;
  } widths_t;

  function automatic logic [3:0] clamp_width(input logic [3:0] n);
    return (n > WIDTH_MAX) ? WIDTH_MAX : n;
  endfunction

  // Low n bits set, n in 0..8
  function automatic logic [7:0] field_mask(input logic [3:0] n);
    logic [8:0] t;
    t = (9'd1 << n) - 9'd1;
    return t[7:0];
  endfunction

  // ceil(2^24 / (2^n - 1)); quotient of 255*v by (2^n-1) is (x*M) >> 24
  function automatic logic [24:0] scale_recip(input logic [3:0] n);
    logic [24:0] m;
    unique case (n)
      4'd1:    m = 25'd16777216;
      4'd2:    m = 25'd5592406;
      4'd3:    m = 25'd2396746;
      4'd4:    m = 25'd1118482;
      4'd5:    m = 25'd541201;
      4'd6:    m = 25'd266306;
      4'd7:    m = 25'd132105;
      4'd8:    m = 25'd65794;
      default: m = 25'd0;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/prid_front.sv =====
// Front end: takes input requests, classifies them and feeds the queue.
// Depends on prid_pkg.
module prid_front
  import prid_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  palette_slot,
  input  logic [23:0] packed_colour,
  input  logic [7:0]  stream_byte,
  input  logic [15:0] row_pixels,
  input  logic        q_full,
  output logic        q_push,
  output item_t       q_item
);

  logic  hold_valid;
  item_t hold_item;
  item_t cls_item;
  logic  keep;
  logic  accept;

  // Classify the incoming request
  always_comb begin
    keep          = 1'b1;
    cls_item.cls  = CL_START;
    cls_item.data = '0;
    unique case (mode)
      MODE_PAL: begin
        cls_item.cls  = CL_PAL;
        cls_item.data = {palette_slot, packed_colour};
      end
      MODE_BYTE: begin
        cls_item.data = {24'd0, stream_byte};
        if (stream_byte == 8'd0) begin
          cls_item.cls = CL_ZERO;
        end else if (stream_byte[7]) begin
          cls_item.cls = CL_RUN;
        end else begin
          cls_item.cls = CL_COUNT;
        end
      end
      MODE_START: begin
        cls_item.cls  = CL_START;
        cls_item.data = {16'd0, row_pixels};
      end
      MODE_NONE: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push   = hold_valid && !q_full;
  assign in_stall = hold_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_item   = hold_item;

  // Holding register in front of the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= keep;
    end else if (q_push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_item <= cls_item;
    end
  end

endmodule

// ===== rtl/prid_queue.sv =====
// Short request queue between the front end and the back end.
// Depends on prid_pkg.
module prid_queue
  import prid_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t pop_item,
  output logic  empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  item_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push_ok;
  logic             pop_ok;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign push_ok  = push && !full;
  assign pop_ok   = pop && !empty;
  assign pop_item = entries[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push_ok) - CNT_W'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== rtl/prid_back.sv =====
// Back end: palette scaling and storage, run-length decode, result register.
// Depends on prid_pkg and assert_macros.svh.
`include "assert_macros.svh"
module prid_back
  import prid_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256,
  parameter int WIDTH_BITS    = 16
)
(
  input  logic        clk,
  input  logic        rst,
  input  widths_t     widths,
  input  logic        q_empty,
  output logic        q_pop,
  input  item_t       q_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        pixel_kind,
  output logic [15:0] pixel_count,
  output logic [31:0] argb_colour,
  output logic        row_done,
  output logic        row_overflow
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_WR   = 4'b0100,
    ST_PIX  = 4'b1000
  } state_t;

  state_t                state;
  logic [6:0]            opaque_left;
  logic [16:0]           row_fill;
  logic [WIDTH_BITS-1:0] width_held;

  logic [23:0] colour_table [TABLE_ENTRIES];
  logic [23:0] rd_data;
  logic        rd_hit;

  logic [2:0][15:0] mul_x;
  logic [2:0][24:0] mul_m;
  logic [2:0][7:0]  scaled;
  logic [7:0]       wr_slot;
  logic             wr_hit;

  logic             out_free;
  logic             out_load;
  logic             owed;
  logic             pix_take;
  logic             count_take;
  logic [7:0]       byte_in;
  logic [17:0]      fill_sum;
  logic [16:0]      fill_new;
  logic [16:0]      width_ext;
  logic [3:0]       rw;
  logic [3:0]       gw;
  logic [3:0]       bw;
  logic [4:0]       sh_r;
  logic [23:0]      word;
  logic [2:0][7:0]  fld;
  logic [2:0][3:0]  fw;
  logic [2:0][15:0] x_next;
  logic [2:0][24:0] m_next;
  logic [2:0][40:0] prod;

  assign out_free  = !out_valid || !out_stall;
  assign q_pop     = (state == ST_IDLE) && !q_empty && out_free;
  assign owed      = (opaque_left != 7'd0);
  assign byte_in   = q_item.data[7:0];
  assign pix_take  = q_pop && owed &&
                     (q_item.cls == CL_ZERO || q_item.cls == CL_RUN ||
                      q_item.cls == CL_COUNT);
  assign count_take = q_pop && !owed && q_item.cls == CL_COUNT;
  assign out_load  = (q_pop && !owed &&
                      (q_item.cls == CL_ZERO || q_item.cls == CL_RUN)) ||
                     (state == ST_PIX && out_free);
  assign fill_sum  = 18'(row_fill) + 18'(byte_in[6:0]);
  assign fill_new  = fill_sum[17] ? FILL_MAX : fill_sum[16:0];
  assign width_ext = 17'(width_held);

  // Unpack the colour word; blue sits lowest, red above green
  always_comb begin
    rw     = clamp_width(widths.red);
    gw     = clamp_width(widths.green);
    bw     = clamp_width(widths.blue);
    sh_r   = 5'(bw) + 5'(gw);
    word   = q_item.data[23:0];
    fld[2] = 8'(word >> sh_r) & field_mask(rw);
    fld[1] = 8'(word >> bw) & field_mask(gw);
    fld[0] = word[7:0] & field_mask(bw);
    fw[2]  = rw;
    fw[1]  = gw;
    fw[0]  = bw;
    for (int i = 0; i < 3; i++) begin
      x_next[i] = {fld[i], 8'h00} - {8'h00, fld[i]};
      m_next[i] = scale_recip(fw[i]);
    end
  end

  // Reciprocal multiply per channel, quotient in bits 31:24
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = 41'(mul_x[i]) * 41'(mul_m[i]);
    end
  end

  // Scaling pipeline registers
  always_ff @(posedge clk) begin
    if (q_pop && q_item.cls == CL_PAL) begin
      mul_x   <= x_next;
      mul_m   <= m_next;
      wr_slot <= q_item.data[31:24];
      wr_hit  <= (9'(q_item.data[31:24]) < 9'(TABLE_ENTRIES));
    end
    if (state == ST_MUL) begin
      for (int i = 0; i < 3; i++) begin
        scaled[i] <= prod[i][31:24];
      end
    end
  end

  // Palette memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state == ST_WR && wr_hit) begin
      colour_table[wr_slot[IDX_W-1:0]] <= {scaled[2], scaled[1], scaled[0]};
    end
    if (pix_take) begin
      rd_data <= colour_table[byte_in[IDX_W-1:0]];
      rd_hit  <= (9'(byte_in) < 9'(TABLE_ENTRIES));
    end
  end

  // Sequencer and decode counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      opaque_left <= 7'd0;
      row_fill    <= 17'd0;
      width_held  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (pix_take) begin
            opaque_left <= opaque_left - 7'd1;
            state       <= ST_PIX;
          end else if (q_pop) begin
            unique case (q_item.cls)
              CL_PAL: begin
                state <= ST_MUL;
              end
              CL_START: begin
                width_held  <= q_item.data[WIDTH_BITS-1:0];
                opaque_left <= 7'd0;
                row_fill    <= 17'd0;
              end
              CL_ZERO: begin
                row_fill <= 17'd0;
              end
              CL_RUN: begin
                row_fill <= fill_new;
              end
              CL_COUNT: begin
                opaque_left <= byte_in[6:0];
                row_fill    <= fill_new;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_MUL: begin
          state <= ST_WR;
        end
        ST_WR: begin
          state <= ST_IDLE;
        end
        ST_PIX: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result valid: set on load, cleared once the result is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (state == ST_PIX && out_free) begin
      pixel_kind   <= 1'b1;
      pixel_count  <= 16'd1;
      argb_colour  <= {ALPHA_OPAQUE, rd_hit ? rd_data : 24'd0};
      row_done     <= 1'b0;
      row_overflow <= 1'b0;
    end else if (q_pop && !owed && q_item.cls == CL_ZERO) begin
      pixel_kind   <= 1'b0;
      argb_colour  <= 32'd0;
      row_done     <= 1'b1;
      if (row_fill > width_ext) begin
        pixel_count  <= 16'd0;
        row_overflow <= 1'b1;
      end else begin
        pixel_count  <= 16'(width_ext - row_fill);
        row_overflow <= 1'b0;
      end
    end else if (q_pop && !owed && q_item.cls == CL_RUN) begin
      pixel_kind   <= 1'b0;
      pixel_count  <= 16'(byte_in[6:0]);
      argb_colour  <= 32'd0;
      row_done     <= 1'b0;
      row_overflow <= 1'b0;
    end
  end

  // Palette write always runs multiply then memory write
  `PRID_ASSERT_NXT(a_mul_then_wr, clk, rst, state == ST_MUL, state == ST_WR, "write skipped")
  // A pixel lookup only starts while indexes are owed
  `PRID_ASSERT_IMP(a_pix_owed, clk, rst, $rose(state == ST_PIX), $past(owed), "no index owed")
  // A count byte always leaves indexes owed
  `PRID_ASSERT_NXT(a_count_loads, clk, rst, count_take, owed, "count byte lost")

endmodule

// ===== rtl/palette_rle_image_decoder_core.sv =====
// Palette run-length image decoder, top level: APB registers and wiring.
// Depends on prid_pkg, prid_front, prid_queue and prid_back.
//
// Requests enter through a holding register and a four-entry queue; the
// back end takes one request from the queue when idle and its result
// register can be loaded. Row ends, transparent runs, index-count bytes and
// image starts stay in the idle state. An opaque pixel adds the pixel state
// for the registered palette read. A palette write is a multiply stage that
// scales the three channels by constant reciprocals, a register, then the
// memory write. Palette entries are undefined until written; there is no
// clearing pass after reset. Colour widths are set through the APB port at
// 0x0 (red), 0x4 (green) and 0x8 (blue); the user must write them only
// while the decoder is idle, which the block itself does not enforce.
module palette_rle_image_decoder_core
  import prid_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256,
  parameter int WIDTH_BITS    = 16
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  palette_slot,
  input  logic [23:0] packed_colour,
  input  logic [7:0]  stream_byte,
  input  logic [15:0] row_pixels,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        pixel_kind,
  output logic [15:0] pixel_count,
  output logic [31:0] argb_colour,
  output logic        row_done,
  output logic        row_overflow
);

  widths_t widths;
  logic    cfg_wr;
  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;
  item_t   push_item;
  item_t   pop_item;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Colour width registers
  always_ff @(posedge clk) begin
    if (rst) begin
      widths.red   <= WIDTH_RESET;
      widths.green <= WIDTH_RESET;
      widths.blue  <= WIDTH_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_RED:   widths.red   <= pwdata[3:0];
        REG_GREEN: widths.green <= pwdata[3:0];
        REG_BLUE:  widths.blue  <= pwdata[3:0];
        default:   widths.red   <= widths.red;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (paddr[3:2])
      REG_RED:   prdata = {28'd0, widths.red};
      REG_GREEN: prdata = {28'd0, widths.green};
      REG_BLUE:  prdata = {28'd0, widths.blue};
      default:   prdata = 32'd0;
    endcase
  end

  prid_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .palette_slot  (palette_slot),
    .packed_colour (packed_colour),
    .stream_byte   (stream_byte),
    .row_pixels    (row_pixels),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  prid_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  prid_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .WIDTH_BITS    (WIDTH_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .widths       (widths),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_item       (pop_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_kind   (pixel_kind),
    .pixel_count  (pixel_count),
    .argb_colour  (argb_colour),
    .row_done     (row_done),
    .row_overflow (row_overflow)
  );

endmodule

// ===== bench/palette_rle_image_decoder_core_tb.sv =====
// Self-checking testbench for the palette run-length image decoder core.
// Depends on prid_pkg and palette_rle_image_decoder_core; reads nothing else.
// A directed table is followed by random images checked against a local decoder model.
module palette_rle_image_decoder_core_tb;
  import prid_pkg::*;

  localparam int HOLD_CYCLES    = 120;
  localparam int DRAIN_CYCLES   = 24;
  localparam int PHASE_REQUESTS = 75;
  localparam int SAT_RUNS       = 1040;
  localparam int PHASES         = 8;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  slot;
    logic [23:0] colour;
    logic [7:0]  data_byte;
    logic [15:0] width;
  } request_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] count;
    logic [31:0] argb;
    logic        done;
    logic        over;
  } pixel_t;

  // Directed row: request, and a typed-in pixel where one is obvious
  typedef struct packed {
    request_t rq;
    logic     typed;
    pixel_t   px;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  mode;
  logic [7:0]  palette_slot;
  logic [23:0] packed_colour;
  logic [7:0]  stream_byte;
  logic [15:0] row_pixels;
  logic        out_valid;
  logic        out_stall;
  logic        pixel_kind;
  logic [15:0] pixel_count;
  logic [31:0] argb_colour;
  logic        row_done;
  logic        row_overflow;

  palette_rle_image_decoder_core dut (.*);

  // Decoder model state and its copy of the width registers
  logic [23:0] colour_table [256];
  bit          painted [256];
  logic [7:0]  painted_slots [$];
  logic [6:0]  owed;
  logic [16:0] fill;
  logic [15:0] image_width;
  logic [3:0]  red_w;
  logic [3:0]  green_w;
  logic [3:0]  blue_w;

  pixel_t pixels_due [$];
  pixel_t due_px;
  int     mismatches    = 0;
  int     requests_taken = 0;
  int     pixels_seen   = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     holds_asked   = 0;
  int     holds_served  = 0;

  stim_row_t directed_rows [0:24] = '{
    '{'{MODE_START, 8'h00, 24'h000000, 8'h00, 16'd10},   1'b0, '0},
    '{'{MODE_BYTE,  8'h00, 24'h000000, 8'h00, 16'd0},    1'b1, '{1'b0, 16'd10, 32'h0, 1'b1, 1'b0}},
    '{'{MODE_PAL,   8'h00, 24'h000000, 8'h00, 16'd0},    1'b0, '0},
    '{'{MODE_PAL,   8'hff, 24'hffffff, 8'h00, 16'd0},    1'b0, '0},
    '{'{MODE_PAL,   8'h01, 24'h123456, 8'h00, 16'd0},    1'b0, '0},
    '{'{MODE_BYTE,  8'h00, 24'h000000, 8'h80, 16'd0},    1'b1, '{1'b0, 16'd0, 32'h0, 1'b0, 1'b0}},
    '{'{MODE_BYTE,  8'h00, 24'h000000, 8'hff, 16'd0},    1'b1, '{1'b0, 16'd127, 32'h0, 1'b0, 1'b0}},
    '{'{MODE_BYTE,  8'h00, 24'h000000, 8'h00, 16'd0},    1'b1, '{1'b0, 16'd0, 32'h0, 1'b1, 1'b1}},
    '{'{MODE_BYTE,  8'h00, 24'h000000, 8'h03, 16'd0},    1'b0, '0},
    '{'{MODE_BYTE,  8'h00, 24'h000000, 8'hff, 16'd0},    1'b1,
      '{1'b1, 16'd1, 32'hffffffff, 1'b0, 1'b0}},
    '{'{MODE_BYTE,  8'h00, 24'h000000, 8'h00, 16'd0},    1'b1,
      '{1'b1, 16'd1, 32'hff000000, 1'b0, 1'b0}},
    '{'{MODE_BYTE,  8'h00, 24'h000000, 8'h01, 16'd0},    1'b1,
      '{1'b1, 16'd1, 32'hff123456, 1'b0, 1'b0}},
    '{'{MODE_BYTE,  8'h00, 24'h000000, 8'h00, 16'd0},    1'b1, '{1'b0, 16'd7, 32'h0, 1'b1, 1'b0}},
    '{'{MODE_BYTE,  8'h00, 24'h000000, 8'h01, 16'd0},    1'b0, '0},
    '{'{MODE_NONE,  8'haa, 24'h555555, 8'h00, 16'hffff}, 1'b0, '0},
    '{'{MODE_BYTE,  8'h00, 24'h000000, 8'hff, 16'd0},    1'b1,
      '{1'b1, 16'd1, 32'hffffffff, 1'b0, 1'b0}},
    '{'{MODE_START, 8'h00, 24'h000000, 8'h00, 16'hffff}, 1'b0, '0},
    '{'{MODE_BYTE,  8'h00, 24'h000000, 8'h85, 16'd0},    1'b1, '{1'b0, 16'd5, 32'h0, 1'b0, 1'b0}},
    '{'{MODE_BYTE,  8'h00, 24'h000000, 8'h00, 16'd0},    1'b1,
      '{1'b0, 16'd65530, 32'h0, 1'b1, 1'b0}},
    '{'{MODE_BYTE,  8'h00, 24'h000000, 8'h02, 16'd0},    1'b0, '0},
    '{'{MODE_START, 8'h00, 24'h000000, 8'h00, 16'd3},    1'b0, '0},
    '{'{MODE_BYTE,  8'h00, 24'h000000, 8'h00, 16'd0},    1'b1, '{1'b0, 16'd3, 32'h0, 1'b1, 1'b0}},
    '{'{MODE_BYTE,  8'h00, 24'h000000, 8'h83, 16'd0},    1'b1, '{1'b0, 16'd3, 32'h0, 1'b0, 1'b0}},
    '{'{MODE_BYTE,  8'h00, 24'h000000, 8'h00, 16'd0},    1'b1, '{1'b0, 16'd0, 32'h0, 1'b1, 1'b0}},
    '{'{MODE_PAL,   8'h02, 24'ha5c3f0, 8'h00, 16'd0},    1'b0, '0}
  };

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Channel scaled to 8 bits: 255*v/(2^n-1), zero for an empty channel
  function automatic logic [7:0] expand_channel(input int unsigned v, input int unsigned n);
    if (n == 0) return 8'd0;
    return 8'((255 * v) / ((1 << n) - 1));
  endfunction

  // Advance the model by one request; returns the pixel it produces, if any
  task automatic decode_step(input request_t rq, output bit has_px, output pixel_t px);
    int unsigned rw, gw, bw, word, total;
    has_px = 1'b0;
    px = '0;
    case (rq.mode)
      MODE_PAL: begin
        rw = 32'(clamp_width(red_w));
        gw = 32'(clamp_width(green_w));
        bw = 32'(clamp_width(blue_w));
        word = 32'(rq.colour);
        colour_table[rq.slot] = {
          expand_channel((word >> (bw + gw)) & ((1 << rw) - 1), rw),
          expand_channel((word >> bw) & ((1 << gw) - 1), gw),
          expand_channel(word & ((1 << bw) - 1), bw)};
        if (!painted[rq.slot]) begin
          painted[rq.slot] = 1'b1;
          painted_slots.push_back(rq.slot);
        end
      end
      MODE_START: begin
        image_width = rq.width;
        owed = '0;
        fill = '0;
      end
      MODE_BYTE: begin
        has_px = 1'b1;
        total = 0;
        if (owed != 0) begin
          // palette index owed by an earlier count byte
          px.kind = 1'b1;
          px.count = 16'd1;
          px.argb = {ALPHA_OPAQUE, colour_table[rq.data_byte]};
          owed = owed - 7'd1;
        end else if (rq.data_byte == 8'h00) begin
          // row end: padding to the width, or overflow
          px.done = 1'b1;
          if (fill > 17'(image_width)) px.over = 1'b1;
          else px.count = image_width - fill[15:0];
          fill = '0;
        end else begin
          if (rq.data_byte[7]) px.count = 16'(rq.data_byte[6:0]);
          else begin
            has_px = 1'b0;
            owed = rq.data_byte[6:0];
          end
          total = 32'(fill) + 32'(rq.data_byte[6:0]);
          fill = (total > 32'(FILL_MAX)) ? FILL_MAX : 17'(total);
        end
      end
      default: ;
    endcase
  endtask

  // Offer one request, wait for it to be taken, then maybe idle the sender
  task automatic send(input request_t rq, input bit typed, input pixel_t typed_px);
    bit has_px;
    pixel_t px;
    mode = rq.mode;
    palette_slot = rq.slot;
    packed_colour = rq.colour;
    stream_byte = rq.data_byte;
    row_pixels = rq.width;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    decode_step(rq, has_px, px);
    if (typed) pixels_due.push_back(typed_px);
    else if (has_px) pixels_due.push_back(px);
    if (rq.mode != MODE_NONE) requests_taken++;
    @(negedge clk);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  function automatic request_t any_request();
    request_t rq;
    rq.mode = 2'($urandom_range(0, 3));
    rq.slot = 8'($urandom);
    rq.colour = 24'($urandom);
    rq.data_byte = 8'($urandom);
    rq.width = 16'($urandom);
    return rq;
  endfunction

  function automatic logic [7:0] pick_index();
    return painted_slots[$urandom_range(0, painted_slots.size() - 1)];
  endfunction

  task automatic send_byte(input logic [7:0] b);
    request_t rq;
    rq = any_request();
    rq.mode = MODE_BYTE;
    rq.data_byte = b;
    send(rq, 1'b0, '0);
  endtask

  task automatic send_start(input logic [15:0] w);
    request_t rq;
    rq = any_request();
    rq.mode = MODE_START;
    rq.width = w;
    send(rq, 1'b0, '0);
  endtask

  // Any mode, any fields; bytes stay valid indexes while some are owed
  task automatic send_noise();
    request_t rq;
    rq = any_request();
    if (rq.mode == MODE_BYTE && owed != 0) rq.data_byte = pick_index();
    send(rq, 1'b0, '0);
  endtask

  // One row: transparent runs, opaque spans and an occasional noise request, then a row end
  task automatic send_row();
    int n;
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 12) : $urandom_range(0, 127);
          send_byte({1'b1, 7'(n)});
        end
        9: send_noise();
        default: begin
          n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(1, 20);
          send_byte({1'b0, 7'(n)});
          repeat (n) send_byte(pick_index());
        end
      endcase
      // a stray noise request may have left indexes owed
      while (owed != 0) send_byte(pick_index());
    end
    send_byte(8'h00);
  endtask

  task automatic send_image();
    int k;
    logic [15:0] w;
    k = $urandom_range(0, 9);
    if (k < 7) w = 16'($urandom_range(0, 40));
    else if (k < 9) w = 16'($urandom);
    else w = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
    send_start(w);
    repeat ($urandom_range(1, 3)) send_row();
  endtask

  // Truncated opaque span followed by random requests
  task automatic send_broken();
    int n;
    // close any span still open so the count byte is not taken as an index
    while (owed != 0) send_byte(pick_index());
    n = $urandom_range(2, 12);
    send_byte(8'(n));
    repeat ($urandom_range(0, n - 1)) send_byte(pick_index());
    repeat ($urandom_range(1, 5)) send_noise();
  endtask

  // Stall the output for a long stretch while transparent runs keep coming
  task automatic send_backlog();
    send_start(16'($urandom));
    holds_asked++;
    repeat (40) send_byte({1'b1, 7'($urandom_range(0, 127))});
  endtask

  // Sender pause until every expected pixel is in, plus the drain time
  task automatic wait_idle();
    in_valid = 1'b0;
    while (pixels_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle
  task automatic write_width(input logic [1:0] idx, input logic [3:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = {28'd0, value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      REG_RED:   red_w = value;
      REG_GREEN: green_w = value;
      REG_BLUE:  blue_w = value;
      default: ;
    endcase
  endtask

  task automatic set_widths(input logic [3:0] r, input logic [3:0] g, input logic [3:0] b);
    wait_idle();
    write_width(REG_RED, r);
    write_width(REG_GREEN, g);
    write_width(REG_BLUE, b);
  endtask

  // Output stall: random, or a long hold when one is asked for
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != holds_asked) begin
        holds_served++;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_stall = ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Pixel checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      pixels_seen++;
      if (pixels_due.size() == 0) begin
        $error("pixel result with none expected: kind %0d count %0d argb 0x%0h",
               pixel_kind, pixel_count, argb_colour);
        mismatches++;
      end else begin
        due_px = pixels_due.pop_front();
        check_field("pixel_kind", due_px.kind, pixel_kind);
        check_field("pixel_count", due_px.count, pixel_count);
        check_field("argb_colour", due_px.argb, argb_colour);
        check_field("row_done", due_px.done, row_done);
        check_field("row_overflow", due_px.over, row_overflow);
      end
    end
  end

  // Stimulus
  initial begin
    logic [11:0] widths [PHASES];
    int base;
    int waited;
    widths[0] = {4'd8, 4'd8, 4'd8};
    widths[1] = {4'd0, 4'd0, 4'd0};
    widths[2] = {4'd1, 4'd1, 4'd1};
    widths[3] = {4'd5, 4'd6, 4'd5};
    widths[4] = {4'd15, 4'd9, 4'd12};
    widths[5] = {4'd3, 4'd3, 4'd2};
    widths[6] = {4'd4, 4'd4, 4'd4};
    widths[7] = {4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                 4'($urandom_range(0, 15))};
    owed = '0;
    fill = '0;
    image_width = '0;
    red_w = WIDTH_RESET;
    green_w = WIDTH_RESET;
    blue_w = WIDTH_RESET;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    mode = MODE_PAL;
    palette_slot = '0;
    packed_colour = '0;
    stream_byte = '0;
    row_pixels = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      // sender-light then receiver-light idling, then none
      send_idle_pct = (p < 3) ? 23 : (p < 6) ? 58 : 0;
      recv_idle_pct = (p < 3) ? 58 : (p < 6) ? 23 : 0;
      set_widths(widths[p][11:8], widths[p][7:4], widths[p][3:0]);
      if (p == 0) begin
        foreach (directed_rows[i])
          send(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].px);
      end
      if (p == 1 || p == 4) send_backlog();
      if (p == 7) begin
        // row counter saturation, closed by an overflowing row end
        send_start(16'hffff);
        repeat (SAT_RUNS) send_byte(8'hff);
        send_byte(8'h00);
      end
      base = requests_taken;
      while (requests_taken - base < PHASE_REQUESTS) begin
        if ($urandom_range(0, 9) < 8) send_image();
        else send_broken();
        if (p == 5 && requests_taken - base >= PHASE_REQUESTS / 2 && owed == 0) begin
          wait_idle();
          base = base - PHASE_REQUESTS;
        end
      end
    end

    in_valid = 1'b0;
    waited = 0;
    while (pixels_due.size() != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pixels_due.size() != 0) begin
      $error("%0d expected pixel results never arrived", pixels_due.size());
      mismatches++;
    end

    $display("Decoded %0d requests into %0d pixel results over %0d colour width settings,",
             requests_taken, pixels_seen, PHASES);
    $display("with %0d palette entries, a saturated row counter and two long output holds.",
             painted_slots.size());
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
